[rtl/core/line_position_estimator_macros.svh]
// Assertion macros shared by the line position estimator RTL.
`ifndef LINE_POSITION_ESTIMATOR_MACROS_SVH
`define LINE_POSITION_ESTIMATOR_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, held off while reset is high.
`define LPE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("line position estimator assertion failed");

// Next-cycle implication, held off while reset is high.
`define LPE_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("line position estimator assertion failed");

`else

`define LPE_ASSERT_IMP(label, clk, rst, ante, cons)
`define LPE_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

[rtl/core/lpe_pkg.sv]
// Shared types and constants of the line position estimator.
`default_nettype none

package lpe_pkg;

  localparam int MAX_SENSORS = 8;
  localparam int FULL_SCALE  = 1000;
  localparam int SEEN_LEVEL  = 200;
  localparam int NOISE_LEVEL = 50;
  localparam int WINDOW_HALF = 2;
  localparam int MAX_CENTROID = MAX_SENSORS * FULL_SCALE;

  localparam int VAL_W     = 10;
  localparam int POS_W     = 14;
  localparam int LAST_W    = 13;
  localparam int PROD_W    = 23;
  localparam int WSUM_W    = 26;
  localparam int TOTAL_W   = 13;
  localparam int SCOUNT_W  = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 4;

  localparam int SENSOR_COUNT_RST = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENSOR_COUNT    = 2'd0,
    REG_POSITION_METHOD = 2'd1,
    REG_INVERT_READINGS = 2'd2,
    REG_MANUAL_MODE     = 2'd3
  } lpe_reg_t;

  typedef struct packed {
    logic [VAL_W-1:0] value_0;
    logic [VAL_W-1:0] value_1;
    logic [VAL_W-1:0] value_2;
    logic [VAL_W-1:0] value_3;
    logic [VAL_W-1:0] value_4;
    logic [VAL_W-1:0] value_5;
    logic [VAL_W-1:0] value_6;
    logic [VAL_W-1:0] value_7;
  } lpe_in_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             line_seen;
  } lpe_out_t;

  typedef struct packed {
    logic done;
    logic seen;
  } lpe_merge_stat_t;

endpackage

`default_nettype wire

[rtl/core/lpe_lane.sv]
// One sensor lane: saturate, optionally invert, threshold and weight a reading.
`default_nettype none

module lpe_lane #(
  parameter int LANE_INDEX = 0
) (
  input  logic                       clk,
  input  logic                       load,
  input  logic [lpe_pkg::VAL_W-1:0]  raw,
  input  logic                       invert,
  output logic [lpe_pkg::VAL_W-1:0]  v,
  output logic                       gt50,
  output logic                       gt200,
  output logic [lpe_pkg::PROD_W-1:0] prod
);
  import lpe_pkg::*;

  localparam int WEIGHT = (LANE_INDEX + 1) * FULL_SCALE;
  localparam logic [VAL_W-1:0] FS = VAL_W'(FULL_SCALE);

  logic [VAL_W-1:0]  sat;
  logic [VAL_W-1:0]  cond;
  logic [PROD_W-1:0] prod_next;

  always_comb begin
    sat       = (raw > FS) ? FS : raw;
    cond      = invert ? (FS - sat) : sat;
    prod_next = PROD_W'(cond) * PROD_W'(WEIGHT);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      v     <= cond;
      gt50  <= cond > VAL_W'(NOISE_LEVEL);
      gt200 <= cond > VAL_W'(SEEN_LEVEL);
      prod  <= prod_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/lpe_merge.sv]
// Merge stage: peak search across lanes, then, when a line is seen, lane-by-lane centroid sums.
`default_nettype none
`include "line_position_estimator_macros.svh"

module lpe_merge #(
  parameter int NUM_SENSORS = lpe_pkg::MAX_SENSORS,
  localparam int IDX_W = $clog2(NUM_SENSORS),
  localparam int CNT_W = $clog2(NUM_SENSORS + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [CNT_W-1:0]            count,
  input  logic                        method,
  input  logic [lpe_pkg::VAL_W-1:0]   lane_v    [NUM_SENSORS],
  input  logic [NUM_SENSORS-1:0]      lane_gt50,
  input  logic [NUM_SENSORS-1:0]      lane_gt200,
  input  logic [lpe_pkg::PROD_W-1:0]  lane_prod [NUM_SENSORS],
  output lpe_pkg::lpe_merge_stat_t    stat,
  output logic [lpe_pkg::WSUM_W-1:0]  weighted,
  output logic [lpe_pkg::TOTAL_W-1:0] total
);
  import lpe_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE = 3'b001,
    M_FIND = 3'b010,
    M_SUM  = 3'b100
  } merge_state_t;

  merge_state_t     state;
  logic             done;
  logic             seen;
  logic [IDX_W-1:0] at;
  logic [IDX_W-1:0] idx;

  logic             seen_next;
  logic [IDX_W-1:0] at_next;
  logic [VAL_W-1:0] peak;
  logic             in_window;
  logic             take;
  logic             last;

  // First strict maximum above the seen level among the lanes in use.
  always_comb begin
    seen_next = 1'b0;
    at_next   = '0;
    peak      = '0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      if (CNT_W'(i) < count && lane_gt200[i]) begin
        seen_next = 1'b1;
        if (lane_v[i] > peak) begin
          peak    = lane_v[i];
          at_next = IDX_W'(i);
        end
      end
    end
  end

  always_comb begin
    in_window = ((IDX_W+1)'(idx) + (IDX_W+1)'(WINDOW_HALF) >= (IDX_W+1)'(at)) &&
                ((IDX_W+1)'(idx) <= (IDX_W+1)'(at) + (IDX_W+1)'(WINDOW_HALF));
    take      = method ? (lane_gt200[idx] && in_window) : lane_gt50[idx];
    last      = (CNT_W'(idx) + CNT_W'(1)) == count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        M_IDLE: begin
          if (start) state <= M_FIND;
        end
        M_FIND: begin
          if (seen_next) begin
            state <= M_SUM;
          end else begin
            state <= M_IDLE;
            done  <= 1'b1;
          end
        end
        M_SUM: begin
          if (last) begin
            state <= M_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      M_FIND: begin
        seen     <= seen_next;
        at       <= at_next;
        idx      <= '0;
        weighted <= '0;
        total    <= '0;
      end
      M_SUM: begin
        if (take) begin
          weighted <= weighted + WSUM_W'(lane_prod[idx]);
          total    <= total + TOTAL_W'(lane_v[idx]);
        end
        idx <= idx + IDX_W'(1);
      end
      default: ;
    endcase
  end

  assign stat = '{done: done, seen: seen};

  `LPE_ASSERT_IMP(a_sum_in_range, clk, rst, state == M_SUM, CNT_W'(idx) < count)

endmodule

`default_nettype wire

[rtl/core/lpe_div.sv]
// Restoring divider: one quotient bit per cycle.
`default_nettype none
`include "line_position_estimator_macros.svh"

module lpe_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [lpe_pkg::WSUM_W-1:0]  dividend,
  input  logic [lpe_pkg::TOTAL_W-1:0] divisor,
  output logic                        done,
  output logic [lpe_pkg::WSUM_W-1:0]  quotient
);
  import lpe_pkg::*;

  localparam int STEP_W = $clog2(WSUM_W);

  logic               busy;
  logic [STEP_W-1:0]  step;
  logic [TOTAL_W-1:0] rem;
  logic [TOTAL_W-1:0] dvs;
  logic [WSUM_W-1:0]  quo;

  logic [TOTAL_W:0]   shifted;
  logic [TOTAL_W:0]   diff;
  logic               fits;
  logic [TOTAL_W-1:0] rem_next;

  always_comb begin
    shifted  = {rem, quo[WSUM_W-1]};
    diff     = shifted - {1'b0, dvs};
    fits     = shifted >= {1'b0, dvs};
    rem_next = fits ? diff[TOTAL_W-1:0] : shifted[TOTAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(WSUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[WSUM_W-2:0], fits};
    end
  end

  assign quotient = quo;

  `LPE_ASSERT_IMP(a_start_when_idle, clk, rst, start, !busy)

endmodule

`default_nettype wire

[rtl/core/line_position_estimator.sv]
// Top level of the line position estimator: config, lanes, merge, divider, output register.
// Manual mode sends a zero result straight to the output register; with no line seen
//   the merge peak search gives a fallback position; with a line seen the lane-by-lane
//   sum and the 26-step serial divider run first. A new item is taken only once the
//   output register has taken the last result (in_stall is high until then).
// Reset (rst, synchronous): config registers and control state back to their defaults, last position zero.
`default_nettype none
`include "line_position_estimator_macros.svh"

module line_position_estimator #(
  parameter int NUM_SENSORS = lpe_pkg::MAX_SENSORS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [lpe_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [lpe_pkg::CFG_DAT_W-1:0] wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  lpe_pkg::lpe_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output lpe_pkg::lpe_out_t             out_data
);
  import lpe_pkg::*;

  localparam int CNT_W = $clog2(NUM_SENSORS + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MRG  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } top_state_t;

  logic [SCOUNT_W-1:0] sensor_count;
  logic                position_method;
  logic                invert_readings;
  logic                manual_mode;
  logic [LAST_W-1:0]   last_position;

  top_state_t          state;
  logic [POS_W-1:0]    res_pos;
  logic                res_seen;

  logic [CNT_W-1:0]    count_used;
  logic [POS_W-1:0]    fb_end;
  logic [POS_W-1:0]    fb_pos;
  logic                in_accept;
  logic                out_load;
  logic                merge_start;
  logic                div_start;

  logic [VAL_W-1:0]    raw        [MAX_SENSORS];
  logic [VAL_W-1:0]    lane_v     [NUM_SENSORS];
  logic [PROD_W-1:0]   lane_prod  [NUM_SENSORS];
  logic [NUM_SENSORS-1:0] lane_gt50;
  logic [NUM_SENSORS-1:0] lane_gt200;

  lpe_merge_stat_t     mstat;
  logic [WSUM_W-1:0]   weighted;
  logic [TOTAL_W-1:0]  total;
  logic                div_done;
  logic [WSUM_W-1:0]   quo;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_count    <= SCOUNT_W'(SENSOR_COUNT_RST);
      position_method <= 1'b0;
      invert_readings <= 1'b0;
      manual_mode     <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        REG_SENSOR_COUNT:    sensor_count    <= wr_data[SCOUNT_W-1:0];
        REG_POSITION_METHOD: position_method <= wr_data[0];
        REG_INVERT_READINGS: invert_readings <= wr_data[0];
        REG_MANUAL_MODE:     manual_mode     <= wr_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (sensor_count == '0) begin
      count_used = CNT_W'(1);
    end else if (sensor_count > SCOUNT_W'(NUM_SENSORS)) begin
      count_used = CNT_W'(NUM_SENSORS);
    end else begin
      count_used = sensor_count[CNT_W-1:0];
    end
    fb_end = (POS_W'(count_used) + POS_W'(1)) * POS_W'(FULL_SCALE);
    // Pin to the end on the side where the line was last seen.
    fb_pos = ({1'b0, last_position} < (fb_end >> 1)) ? '0 : fb_end;
  end

  assign in_stall    = (state != ST_IDLE);
  assign in_accept   = in_valid && !in_stall;
  assign merge_start = in_accept && !manual_mode;
  assign div_start   = (state == ST_MRG) && mstat.done && mstat.seen;
  assign out_load    = (state == ST_FIN) && (!out_valid || !out_stall);

  assign raw[0] = in_data.value_0;
  assign raw[1] = in_data.value_1;
  assign raw[2] = in_data.value_2;
  assign raw[3] = in_data.value_3;
  assign raw[4] = in_data.value_4;
  assign raw[5] = in_data.value_5;
  assign raw[6] = in_data.value_6;
  assign raw[7] = in_data.value_7;

  for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_lane
    lpe_lane #(
      .LANE_INDEX(g)
    ) u_lane (
      .clk   (clk),
      .load  (in_accept),
      .raw   (raw[g]),
      .invert(invert_readings),
      .v     (lane_v[g]),
      .gt50  (lane_gt50[g]),
      .gt200 (lane_gt200[g]),
      .prod  (lane_prod[g])
    );
  end

  lpe_merge #(
    .NUM_SENSORS(NUM_SENSORS)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .start     (merge_start),
    .count     (count_used),
    .method    (position_method),
    .lane_v    (lane_v),
    .lane_gt50 (lane_gt50),
    .lane_gt200(lane_gt200),
    .lane_prod (lane_prod),
    .stat      (mstat),
    .weighted  (weighted),
    .total     (total)
  );

  lpe_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(weighted),
    .divisor (total),
    .done    (div_done),
    .quotient(quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      last_position <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_accept) state <= manual_mode ? ST_FIN : ST_MRG;
        end
        ST_MRG: begin
          if (mstat.done) state <= mstat.seen ? ST_DIV : ST_FIN;
        end
        ST_DIV: begin
          if (div_done) begin
            state         <= ST_FIN;
            last_position <= quo[LAST_W-1:0];
          end
        end
        ST_FIN: begin
          if (out_load) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && manual_mode) begin
      res_pos  <= '0;
      res_seen <= 1'b0;
    end
    if (state == ST_MRG && mstat.done && !mstat.seen) begin
      res_pos  <= fb_pos;
      res_seen <= 1'b0;
    end
    if (state == ST_DIV && div_done) begin
      res_pos  <= quo[POS_W-1:0];
      res_seen <= 1'b1;
    end
    // Hold the result until the output register is free.
    if (out_load) begin
      out_data <= '{position: res_pos, line_seen: res_seen};
    end
  end

  `LPE_ASSERT_NXT(a_busy_after_accept, clk, rst, in_accept, in_stall)
  `LPE_ASSERT_IMP(a_div_done_in_div, clk, rst, div_done, state == ST_DIV)
  `LPE_ASSERT_IMP(a_centroid_range, clk, rst, out_valid && out_data.line_seen,
                  out_data.position <= POS_W'(MAX_CENTROID))

endmodule

`default_nettype wire
